// ===== design/fac_pkg.sv =====
`timescale 1ns / 1ps

package fac_pkg;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int LEVEL_W  = 8;

   // Serial divider for the range map: 20-bit dividend covers the scaled
   // numerator (4095 * 255), 12-bit divisor covers the calibrated range.
   localparam int DIV_NUM_W = 20;
   localparam int DIV_DEN_W = 12;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USABLE_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USABLE_MAX = 2'd2;

   localparam logic [SAMPLE_W-1:0] HYST_RESET = 12'd8;
   localparam logic [SAMPLE_W-1:0] UMIN_RESET = 12'd0;
   localparam logic [SAMPLE_W-1:0] UMAX_RESET = 12'd4095;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

   typedef struct packed {
      logic [SAMPLE_W-1:0] hysteresis;
      logic [SAMPLE_W-1:0] usable_min;
      logic [SAMPLE_W-1:0] usable_max;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/fac_div.sv =====
`timescale 1ns / 1ps

// Restoring long divider, one quotient bit per cycle.
module fac_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fac_pkg::div_req_type div_req,
   output fac_pkg::div_rsp_type div_rsp
);
   import fac_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;

   // load operands on start; else one step: shift in next dividend bit, subtract if it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== design/fac_queue.sv =====
`timescale 1ns / 1ps

// Short register queue between the front and back parts.
module fac_queue #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);
   import fac_pkg::*;

   logic [W-1:0]           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full     = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/fac_front.sv =====
`timescale 1ns / 1ps

// Front part: takes one sample a cycle while the queue has room and sums each group.
module fac_front #(
   parameter int SAMPLES_PER_READING = 16,
   parameter int SUM_W               = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic [fac_pkg::SAMPLE_W-1:0] req_adc_sample,
   output logic                         req_full,
   output logic                         q_push,
   output logic [SUM_W-1:0]             q_data,
   input  logic                         q_full
);
   import fac_pkg::*;

   localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept, last;
   logic [SUM_W-1:0] sum_next;

   // stall the whole front while the queue has no room
   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign last     = (cnt_ff == CNT_W'(SAMPLES_PER_READING - 1));
   assign sum_next = sum_ff + SUM_W'(req_adc_sample);
   assign q_push   = accept && last;
   assign q_data   = sum_next;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/fac_back.sv =====
`timescale 1ns / 1ps

// Back part: mean, EMA, hysteresis, range map, result register.
module fac_back #(
   parameter int SAMPLES_PER_READING = 16,
   parameter int SUM_W               = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fac_pkg::cfg_type             cfg,
   input  logic                         q_empty,
   input  logic [SUM_W-1:0]             q_data,
   output logic                         q_pop,
   output fac_pkg::div_req_type         div_req,
   input  fac_pkg::div_rsp_type         div_rsp,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [fac_pkg::SAMPLE_W-1:0] rsp_mean_sample,
   output logic [fac_pkg::SAMPLE_W-1:0] rsp_smoothed,
   output logic [fac_pkg::SAMPLE_W-1:0] rsp_held_value,
   output logic [fac_pkg::LEVEL_W-1:0]  rsp_level
);
   import fac_pkg::*;

   // mean = (sum * ceil(2^S / N)) >> S, exact for every sum below 2^SUM_W
   localparam int MEAN_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
   localparam int MEAN_MUL_W = SUM_W + 1;
   localparam int MEAN_PROD_W = SUM_W + MEAN_MUL_W;
   localparam logic [MEAN_MUL_W-1:0] MEAN_MUL = MEAN_MUL_W'(
      ((64'd1 << MEAN_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1)
      / 64'(SAMPLES_PER_READING));

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EMA  = 6'b000010,
      ST_HYST = 6'b000100,
      ST_MAP  = 6'b001000,
      ST_MAPW = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [SAMPLE_W-1:0] smooth_ff, smooth_in;
   logic                smooth_primed_ff, smooth_primed_in;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic                held_primed_ff, held_primed_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_mean_ff, out_smooth_ff, out_held_ff;
   logic [LEVEL_W-1:0]  out_level_ff;
   logic                out_load;

   logic [MEAN_PROD_W-1:0] mean_prod;
   logic [SAMPLE_W-1:0]   ema_base;
   logic [SAMPLE_W+2:0]   ema_sum;
   logic [SAMPLE_W-1:0]   diff;
   logic signed [SAMPLE_W:0]  num13, den13;
   logic signed [DIV_NUM_W:0] num255;
   logic [DIV_NUM_W-1:0]  abs_num;
   logic [DIV_DEN_W-1:0]  abs_den;
   logic                  map_zero;

   // group mean by reciprocal multiply
   assign mean_prod = MEAN_PROD_W'(q_data) * MEAN_PROD_W'(MEAN_MUL);

   // EMA: (base*7 + mean) / 8, base is the mean itself on the first reading
   assign ema_base = smooth_primed_ff ? smooth_ff : mean_ff;
   assign ema_sum  = ({ema_base, 3'b000} - (SAMPLE_W + 3)'(ema_base)) + (SAMPLE_W + 3)'(mean_ff);

   assign diff = (smooth_ff > held_ff) ? smooth_ff - held_ff : held_ff - smooth_ff;

   // signed map operands; x*255 as x*256 - x
   assign num13    = $signed({1'b0, held_ff}) - $signed({1'b0, cfg.usable_min});
   assign den13    = $signed({1'b0, cfg.usable_max}) - $signed({1'b0, cfg.usable_min});
   assign num255   = ((DIV_NUM_W + 1)'(num13) <<< 8) - (DIV_NUM_W + 1)'(num13);
   assign abs_num  = num255[DIV_NUM_W] ? DIV_NUM_W'(-num255) : num255[DIV_NUM_W-1:0];
   assign abs_den  = den13[SAMPLE_W] ? DIV_DEN_W'(-den13) : den13[DIV_DEN_W-1:0];
   // empty range, zero offset or opposite signs all end at level 0
   assign map_zero = (den13 == '0) || (num13 == '0) || (num13[SAMPLE_W] != den13[SAMPLE_W]);

   assign out_load = (state_ff == ST_OUT) && (!out_valid_ff || rsp_pop);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      mean_in          = mean_ff;
      smooth_in        = smooth_ff;
      smooth_primed_in = smooth_primed_ff;
      held_in          = held_ff;
      held_primed_in   = held_primed_ff;
      level_in         = level_ff;
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = abs_num;
      div_req.divisor  = abs_den;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               mean_in  = mean_prod[MEAN_SHIFT +: SAMPLE_W];
               state_in = ST_EMA;
            end
         end
         ST_EMA: begin
            smooth_in        = ema_sum[SAMPLE_W+2:3];
            smooth_primed_in = 1'b1;
            state_in         = ST_HYST;
         end
         ST_HYST: begin
            if (!held_primed_ff || diff > cfg.hysteresis) begin
               held_in        = smooth_ff;
               held_primed_in = 1'b1;
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            if (map_zero) begin
               level_in = '0;
               state_in = ST_OUT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_MAPW;
            end
         end
         ST_MAPW: begin
            if (div_rsp.done) begin
               level_in = (|div_rsp.quotient[DIV_NUM_W-1:LEVEL_W]) ? LEVEL_MAX
                        : div_rsp.quotient[LEVEL_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         smooth_ff        <= '0;
         smooth_primed_ff <= 1'b0;
         held_ff          <= '0;
         held_primed_ff   <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         smooth_ff        <= smooth_in;
         smooth_primed_ff <= smooth_primed_in;
         held_ff          <= held_in;
         held_primed_ff   <= held_primed_in;
         out_valid_ff     <= out_valid_in;
      end
      mean_ff  <= mean_in;
      level_ff <= level_in;
      if (out_load) begin
         out_mean_ff   <= mean_ff;
         out_smooth_ff <= smooth_ff;
         out_held_ff   <= held_ff;
         out_level_ff  <= level_ff;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_mean_sample = out_mean_ff;
   assign rsp_smoothed    = out_smooth_ff;
   assign rsp_held_value  = out_held_ff;
   assign rsp_level       = out_level_ff;

endmodule

// ===== design/fader_adc_conditioner.sv =====
`timescale 1ns / 1ps

// Fader ADC conditioner.
// Input queue side: raise req_push with req_adc_sample; the word is taken
// on a clock edge where req_full is low. Result queue side: while rsp_empty
// is low the oldest reading (mean, smoothed, held value, 0..255 level) is
// on the rsp_ ports and is taken on an edge where rsp_pop is high.
// Registers are written through csr_write/csr_index/csr_wdata; index 3 is
// ignored. The user must write them only while the block is idle; the block itself does not enforce this.
// Every SAMPLES_PER_READING samples form one reading and one result word.
// Samples are accepted one per cycle while the two-entry queue between the
// summing front and the back end has room. The back end forms the mean by a
// constant reciprocal multiply, then steps through EMA, hysteresis and the
// range map on the serial divider (skipped when the level is forced to 0)
// before it loads the result word; meanwhile the front goes on summing the
// next group.
// Reset clears the sums, the filter and held state, the queues and restores
// the register defaults. A result word that is not popped holds; the back end
// then stops, the queue fills and req_full rises.
module fader_adc_conditioner #(
   parameter int SAMPLES_PER_READING = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [fac_pkg::SAMPLE_W-1:0]  req_adc_sample,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [fac_pkg::SAMPLE_W-1:0]  rsp_mean_sample,
   output logic [fac_pkg::SAMPLE_W-1:0]  rsp_smoothed,
   output logic [fac_pkg::SAMPLE_W-1:0]  rsp_held_value,
   output logic [fac_pkg::LEVEL_W-1:0]   rsp_level,
   input  logic                          csr_write,
   input  logic [fac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fac_pkg::SAMPLE_W-1:0]  csr_wdata
);
   import fac_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);

   cfg_type          cfg_ff, cfg_in;
   logic             q_push, q_full, q_pop, q_empty;
   logic [SUM_W-1:0] q_push_data, q_pop_data;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_HYSTERESIS: cfg_in.hysteresis = csr_wdata;
            CSR_USABLE_MIN: cfg_in.usable_min = csr_wdata;
            CSR_USABLE_MAX: cfg_in.usable_max = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hysteresis <= HYST_RESET;
         cfg_ff.usable_min <= UMIN_RESET;
         cfg_ff.usable_max <= UMAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fac_front #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING),
      .SUM_W(SUM_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_adc_sample(req_adc_sample),
      .req_full(req_full),
      .q_push(q_push),
      .q_data(q_push_data),
      .q_full(q_full)
   );

   fac_queue #(
      .W(SUM_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .pop_data(q_pop_data),
      .empty(q_empty)
   );

   fac_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   fac_back #(
      .SAMPLES_PER_READING(SAMPLES_PER_READING),
      .SUM_W(SUM_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_empty(q_empty),
      .q_data(q_pop_data),
      .q_pop(q_pop),
      .div_req(div_req),
      .div_rsp(div_rsp),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_mean_sample(rsp_mean_sample),
      .rsp_smoothed(rsp_smoothed),
      .rsp_held_value(rsp_held_value),
      .rsp_level(rsp_level)
   );

endmodule

// ===== design/fac_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the conditioner.
module fac_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_push,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [fac_pkg::SAMPLE_W-1:0]  rsp_mean_sample,
   input logic [fac_pkg::SAMPLE_W-1:0]  rsp_smoothed,
   input logic [fac_pkg::SAMPLE_W-1:0]  rsp_held_value,
   input logic [fac_pkg::LEVEL_W-1:0]   rsp_level,
   input logic                          csr_write,
   input logic [fac_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [fac_pkg::SAMPLE_W-1:0]  csr_wdata
);
   import fac_pkg::*;

   logic                first_ff, first_in;
   logic [SAMPLE_W-1:0] hyst_ff, hyst_in;
   logic [SAMPLE_W-1:0] held_dist;
   logic                in_word;

   assign in_word  = req_push && !req_full;
   assign first_in = first_ff && !(rsp_pop && !rsp_empty);
   assign hyst_in  = (csr_write && csr_index == CSR_HYSTERESIS) ? csr_wdata : hyst_ff;
   assign held_dist = (rsp_held_value > rsp_smoothed) ? rsp_held_value - rsp_smoothed
                    : rsp_smoothed - rsp_held_value;

   // track the first word and the hysteresis setting
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         hyst_ff  <= HYST_RESET;
      end else begin
         first_ff <= first_in;
         hyst_ff  <= hyst_in;
      end
   end

   // reset leaves both queues open and empty
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result word or input stall present after reset");

   // a waiting word is not dropped or changed
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_mean_sample)
         && $stable(rsp_smoothed) && $stable(rsp_held_value) && $stable(rsp_level))
      else $error("waiting result word changed before pop");

   // the first reading seeds the filter and loads the held value
   a_first_seed: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && first_ff |-> rsp_smoothed == rsp_mean_sample
         && rsp_held_value == rsp_smoothed)
      else $error("first reading did not seed filter and held value");

   // the held value never lags the filter by more than the threshold
   a_held_band: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> held_dist <= hyst_ff)
      else $error("held value outside hysteresis band");

   // a sample taken right after reset cannot yield a word in the next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && in_word |=> rsp_empty)
      else $error("result word appeared without a completed reading");

endmodule

bind fader_adc_conditioner fac_checker u_fac_checker (
   .clock(clock),
   .reset(reset),
   .req_push(req_push),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_mean_sample(rsp_mean_sample),
   .rsp_smoothed(rsp_smoothed),
   .rsp_held_value(rsp_held_value),
   .rsp_level(rsp_level),
   .csr_write(csr_write),
   .csr_index(csr_index),
   .csr_wdata(csr_wdata)
);

// ===== sim/tb_fader_adc_conditioner.sv =====
`timescale 1ns / 1ps

module tb_fader_adc_conditioner;
   import fac_pkg::*;

   localparam int READING_SIZE  = 16;
   localparam int RESET_CYCLES  = 12;
   localparam int PHASES        = 9;
   localparam int PHASE_WORDS   = 194;
   localparam int DIRECTED_HIGH = 16;
   localparam int DIRECTED_LOW  = 9;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_AFTER    = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 12'd4095;

   // How the samples of one group are shaped
   typedef enum {
      GROUP_DRIFT,
      GROUP_STEP,
      GROUP_UNIFORM,
      GROUP_RAIL_MIX,
      GROUP_RAIL_HOLD
   } group_shape_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_sample;
      logic [SAMPLE_W-1:0] smoothed;
      logic [SAMPLE_W-1:0] held_value;
      logic [LEVEL_W-1:0]  level;
   } reading_type;

   // Conditioning chain predictor and queue of readings still owed
   class reading_scoreboard;
      logic [SAMPLE_W-1:0] hysteresis;
      logic [SAMPLE_W-1:0] usable_min;
      logic [SAMPLE_W-1:0] usable_max;
      logic [19:0]         group_sum;
      int                  group_count;
      logic [SAMPLE_W-1:0] ema;
      logic [SAMPLE_W-1:0] held;
      bit                  ema_seeded;
      bit                  held_loaded;
      reading_type         owed_q[$];
      int                  checked;
      int                  errors;

      function new();
         hysteresis  = HYST_RESET;
         usable_min  = UMIN_RESET;
         usable_max  = UMAX_RESET;
         group_sum   = '0;
         group_count = 0;
         ema         = '0;
         held        = '0;
         ema_seeded  = 1'b0;
         held_loaded = 1'b0;
         checked     = 0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [SAMPLE_W-1:0] value);
         case (index)
            CSR_HYSTERESIS: hysteresis = value;
            CSR_USABLE_MIN: usable_min = value;
            CSR_USABLE_MAX: usable_max = value;
            default: ;
         endcase
      endfunction

      // Linear map of the calibrated range onto 0..255, truncating toward zero
      function logic [LEVEL_W-1:0] map_level(logic [SAMPLE_W-1:0] x);
         longint span;
         longint lv;
         span = longint'(usable_max) - longint'(usable_min);
         if (span == 0)
            return '0;
         lv = ((longint'(x) - longint'(usable_min)) * longint'(LEVEL_MAX)) / span;
         if (lv < 0)
            lv = 0;
         else if (lv > longint'(LEVEL_MAX))
            lv = longint'(LEVEL_MAX);
         return lv[LEVEL_W-1:0];
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] s);
         reading_type         r;
         logic [SAMPLE_W-1:0] mean;
         logic [SAMPLE_W-1:0] gap;
         group_sum += s;
         group_count++;
         if (group_count < READING_SIZE)
            return;
         mean        = SAMPLE_W'(group_sum / READING_SIZE);
         group_sum   = '0;
         group_count = 0;
         // first mean seeds the average
         if (!ema_seeded) begin
            ema        = mean;
            ema_seeded = 1'b1;
         end
         ema = SAMPLE_W'((ema * 7 + mean) / 8);
         gap = (ema > held) ? ema - held : held - ema;
         if (!held_loaded || gap > hysteresis) begin
            held        = ema;
            held_loaded = 1'b1;
         end
         r.mean_sample = mean;
         r.smoothed    = ema;
         r.held_value  = held;
         r.level       = map_level(held);
         owed_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [SAMPLE_W-1:0] want,
                                  logic [SAMPLE_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (owed_q.size() == 0) begin
            $error("result word with no reading owed: mean %0d", got.mean_sample);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         compare_field("mean_sample", want.mean_sample, got.mean_sample);
         compare_field("smoothed", want.smoothed, got.smoothed);
         compare_field("held_value", want.held_value, got.held_value);
         compare_field("level", {4'b0, want.level}, {4'b0, got.level});
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_push       = 1'b0;
   logic [SAMPLE_W-1:0]  req_adc_sample = '0;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop        = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_mean_sample;
   logic [SAMPLE_W-1:0]  rsp_smoothed;
   logic [SAMPLE_W-1:0]  rsp_held_value;
   logic [LEVEL_W-1:0]   rsp_level;
   logic                 csr_write      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [SAMPLE_W-1:0]  csr_wdata      = '0;

   reading_scoreboard sb = new();

   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_left     = 0;
   bit              hold_done     = 1'b0;
   int              quiet_edges   = 0;
   int              words_sent    = 0;
   group_shape_type group_shape   = GROUP_DRIFT;
   int              group_base    = 0;

   fader_adc_conditioner #(
      .SAMPLES_PER_READING(READING_SIZE)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_adc_sample  (req_adc_sample),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_mean_sample (rsp_mean_sample),
      .rsp_smoothed    (rsp_smoothed),
      .rsp_held_value  (rsp_held_value),
      .rsp_level       (rsp_level),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Observe every handshake at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write)
            sb.write_reg(csr_index, csr_wdata);
         if (req_push && !req_full)
            sb.note_sample(req_adc_sample);
         if (rsp_pop && !rsp_empty)
            sb.check_reading('{rsp_mean_sample, rsp_smoothed, rsp_held_value, rsp_level});
      end
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_edges <= 0;
      else
         quiet_edges <= quiet_edges + 1;
   end

   // Hang detection: nothing moved for too long
   initial begin
      wait (quiet_edges >= STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sb.checked >= HOLD_AFTER) begin
         rsp_pop   <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int clamp_sample(int v);
      if (v < 0)
         return 0;
      if (v > int'(SAMPLE_MAX))
         return int'(SAMPLE_MAX);
      return v;
   endfunction

   // Next sample; the shape is chosen at each group boundary
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int pick;
      int v;
      if (words_sent % READING_SIZE == 0) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            group_shape = GROUP_DRIFT;
            group_base  = clamp_sample(group_base + int'($urandom_range(40)) - 20);
         end else if (pick < 6) begin
            group_shape = GROUP_STEP;
            group_base  = $urandom_range(4095);
         end else if (pick < 8) begin
            group_shape = GROUP_UNIFORM;
         end else if (pick == 8) begin
            group_shape = GROUP_RAIL_MIX;
         end else begin
            group_shape = GROUP_RAIL_HOLD;
            group_base  = $urandom_range(1) ? int'(SAMPLE_MAX) : 0;
         end
      end
      case (group_shape)
         GROUP_UNIFORM:   v = $urandom_range(4095);
         GROUP_RAIL_MIX:  v = $urandom_range(1) ? int'(SAMPLE_MAX) : 0;
         GROUP_RAIL_HOLD: v = group_base;
         default:         v = clamp_sample(group_base + int'($urandom_range(6)) - 3);
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // Offer one word; returns at the falling edge after it was taken
   task automatic send_word(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_adc_sample <= value;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain_readings();
      req_push <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   // All readings out, then room for a partial group still in flight
   task automatic settle_block();
      drain_readings();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [SAMPLE_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic load_phase_config(input int phase);
      case (phase)
         1: begin
            write_csr(CSR_HYSTERESIS, 12'd0);
            write_csr(CSR_USABLE_MIN, 12'd0);
            write_csr(CSR_USABLE_MAX, SAMPLE_MAX);
         end
         2: begin
            write_csr(CSR_HYSTERESIS, SAMPLE_MAX);
            write_csr(CSR_USABLE_MIN, 12'd100);
            write_csr(CSR_USABLE_MAX, 12'd3900);
         end
         3: begin
            // equal bounds: level stays at zero
            write_csr(CSR_HYSTERESIS, 12'd8);
            write_csr(CSR_USABLE_MIN, 12'd2048);
            write_csr(CSR_USABLE_MAX, 12'd2048);
         end
         4: begin
            // inverted bounds
            write_csr(CSR_HYSTERESIS, 12'd30);
            write_csr(CSR_USABLE_MIN, 12'd4000);
            write_csr(CSR_USABLE_MAX, 12'd100);
         end
         5: begin
            write_csr(CSR_HYSTERESIS, 12'd1);
            write_csr(CSR_USABLE_MIN, SAMPLE_MAX);
            write_csr(CSR_USABLE_MAX, 12'd0);
         end
         6: begin
            // one-count range, nearly everything clamps
            write_csr(CSR_HYSTERESIS, 12'd2);
            write_csr(CSR_USABLE_MIN, 12'd1000);
            write_csr(CSR_USABLE_MAX, 12'd1001);
         end
         7: begin
            write_csr(CSR_HYSTERESIS, SAMPLE_W'($urandom_range(63)));
            write_csr(CSR_USABLE_MIN, SAMPLE_W'($urandom_range(2000)));
            write_csr(CSR_USABLE_MAX, SAMPLE_W'($urandom_range(4095, 1500)));
         end
         default: begin
            // unmapped index must leave every register alone
            write_csr(CSR_UNUSED, SAMPLE_W'($urandom_range(4095)));
            write_csr(CSR_HYSTERESIS, 12'd16);
            write_csr(CSR_USABLE_MIN, 12'd512);
            write_csr(CSR_USABLE_MAX, 12'd3584);
         end
      endcase
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Main sequence
   initial begin
      int sent;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         // sender idles 30 / receiver 57, then swapped, then no idling
         case (phase / 3)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         if (phase != 0) begin
            settle_block();
            load_phase_config(phase);
         end else begin
            // full-scale group seeds the filter, then the bottom rail
            repeat (DIRECTED_HIGH) send_word(SAMPLE_MAX);
            repeat (DIRECTED_LOW) send_word('0);
            sent = DIRECTED_HIGH + DIRECTED_LOW;
         end
         while (sent < PHASE_WORDS) begin
            send_word(pick_sample());
            sent++;
            // sender waits once for the block to empty out
            if (phase == 4 && sent == PHASE_WORDS / 2)
               drain_readings();
         end
      end

      drain_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== fader_adc_conditioner.f =====
design/fac_pkg.sv
design/fac_div.sv
design/fac_queue.sv
design/fac_front.sv
design/fac_back.sv
design/fader_adc_conditioner.sv
design/fac_checker.sv
sim/tb_fader_adc_conditioner.sv
